// ----- sv/adbq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adbq_pkg: shared definitions of the axis detent band quantizer
// Field widths, sizing constants, event codes, request and result payloads
// and the percent-to-position scale table.
// ----------------------------------------------------------------------------
package adbq_pkg;

	// sizing
	localparam int NUM_CONTEXTS = 64;
	localparam int NUM_BANDS    = 15;
	localparam int FULL_SCALE   = 2048;

	// field widths
	localparam int OP_W   = 1;
	localparam int CTX_W  = 6;
	localparam int POS_W  = 12;
	localparam int SEL_W  = 4;
	localparam int DATA_W = 17;
	localparam int EV_W   = 5;

	// stored word widths
	localparam int EDGE_W = 7;
	localparam int LAST_W = 12;
	localparam int PROF_W = 17;
	localparam int CTXW_W = LAST_W + PROF_W;

	// profile word layout
	localparam int PROF_INC_BIT = 16;
	localparam int STEP_W       = 8;

	// edges are given in percent
	localparam int EDGE_DIV = 100;

	// derived sizes
	localparam int CTX_AW     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int BAND_DEPTH = NUM_CONTEXTS * NUM_BANDS;
	localparam int BAND_AW    = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
	localparam int KW         = $clog2(NUM_BANDS + 1);
	localparam int EDGE_CNT   = 2 ** EDGE_W;
	localparam int SCALED_W   = $clog2((EDGE_CNT - 1) * FULL_SCALE / EDGE_DIV + 1);
	localparam int CMP_W      = (SCALED_W > POS_W) ? SCALED_W : POS_W;

	// event codes
	localparam logic [EV_W-1:0] EV_NONE = EV_W'(0);
	localparam logic [EV_W-1:0] EV_UP   = EV_W'(1);
	localparam logic [EV_W-1:0] EV_DOWN = EV_W'(2);

	// request opcodes
	localparam logic [OP_W-1:0] OP_SAMPLE = 1'b0;
	localparam logic [OP_W-1:0] OP_WRITE  = 1'b1;

	// word select of the mode and steps word
	localparam logic [SEL_W-1:0] SEL_MODE = SEL_W'(0);

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CTX_W-1:0]  context_req;
		logic [POS_W-1:0]  position;
		logic [SEL_W-1:0]  word_select;
		logic [DATA_W-1:0] word_data;
	} adbq_req_t;

	typedef struct packed {
		logic [CTX_W-1:0] context_out;
		logic [EV_W-1:0]  event_res;
	} adbq_res_t;

	typedef logic [SCALED_W-1:0] scale_tab_t [EDGE_CNT];

	// edge * FULL_SCALE / 100 for every edge code, built at elaboration
	function automatic scale_tab_t build_scale_tab();
		scale_tab_t t;
		for (int i = 0; i < EDGE_CNT; i++) begin
			t[i] = SCALED_W'((i * FULL_SCALE) / EDGE_DIV);
		end
		return t;
	endfunction

	localparam scale_tab_t SCALE_TAB = build_scale_tab();

endpackage

// ----- sv/adbq_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adbq_req_if: request channel
// Valid/ready channel carrying samples and profile word writes.
// ----------------------------------------------------------------------------
interface adbq_req_if import adbq_pkg::*; ();
	logic      valid;
	logic      ready;
	adbq_req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/adbq_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adbq_res_if: result channel
// Valid/ready channel carrying one detent event per sample.
// ----------------------------------------------------------------------------
interface adbq_res_if import adbq_pkg::*; ();
	logic      valid;
	logic      ready;
	adbq_res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/axis_detent_band_quantizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_detent_band_quantizer: joystick axis to detent event converter
// Per-context incremental or band detents over RAM-held profiles and records.
// ----------------------------------------------------------------------------
// Usage:
//   req carries either a sample (op 0: context and position) or a profile
//   word write (op 1: context, word select, data). res returns one result
//   per sample with its context and event code; writes return nothing.
//   Items are taken one at a time. A write passes through fetch and
//   evaluate; a sample through fetch, evaluate and result, a band sample
//   with a walk over its stored edges between: the band walk reads one
//   stored edge per cycle from the edge RAM, so it sets the sample rate.
//   After reset a clearing pass zeroes the edge RAM and the context RAM, one
//   entry a cycle; req.ready stays low meanwhile.
//   A finished result waits in an output register; the next request is taken
//   while it waits, and only the next result stalls when res is held off.
// ----------------------------------------------------------------------------
module axis_detent_band_quantizer import adbq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	adbq_req_if.sink      req,
	adbq_res_if.source    res
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_FETCH  = 6'b000100,
		ST_EVAL   = 6'b001000,
		ST_BAND   = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// request held for the duration of one item
	logic [OP_W-1:0]    op_q;
	logic [CTX_W-1:0]   ctx_q;
	logic [POS_W-1:0]   pos_q;
	logic [SEL_W-1:0]   sel_q;
	logic [DATA_W-1:0]  data_q;
	logic               in_range_q;
	logic [CTX_AW-1:0]  ctx_addr_q;
	logic [BAND_AW-1:0] base_q;

	// band walk
	logic [KW-1:0]       k_q;
	logic [SCALED_W-1:0] lower_q;

	// clearing pass
	logic [BAND_AW-1:0] clr_q;

	// pending and output result
	logic [EV_W-1:0]  pend_ev_q;
	logic             out_valid_q;
	logic [CTX_W-1:0] out_ctx_q;
	logic [EV_W-1:0]  out_ev_q;

	// RAM ports
	logic               ctx_we;
	logic [CTX_AW-1:0]  ctx_waddr;
	logic [CTXW_W-1:0]  ctx_wdata;
	logic [CTXW_W-1:0]  ctx_rdata;
	logic               band_we;
	logic [BAND_AW-1:0] band_waddr;
	logic [EDGE_W-1:0]  band_wdata;
	logic [BAND_AW-1:0] band_raddr;
	logic [EDGE_W-1:0]  band_rdata;

	logic accept;
	logic res_load;

	// decoded context word
	logic [LAST_W-1:0] prev;
	logic [PROF_W-1:0] prof;
	logic [STEP_W-1:0] rise;
	logic [STEP_W-1:0] fall;

	// incremental decision
	logic [LAST_W:0]  up_sum;
	logic             inc_up;
	logic             inc_down;

	// band step decision
	logic [SCALED_W-1:0] scaled;
	logic [CMP_W-1:0]    pos_c;
	logic                ge_lower;
	logic                in_top;
	logic                last_k;
	logic                band_done;
	logic                band_hit;
	logic [KW-1:0]       band_idx;
	logic                band_new;

	// edge write decode
	logic               edge_sel_ok;
	logic [SEL_W-1:0]   edge_num;

	logic [BAND_AW-1:0] base_d;
	logic               in_range_d;

	adbq_ram #(.WIDTH(CTXW_W), .DEPTH(NUM_CONTEXTS)) u_ctx_ram (
		.clk   (clk),
		.we    (ctx_we),
		.waddr (ctx_waddr),
		.wdata (ctx_wdata),
		.raddr (ctx_addr_q),
		.rdata (ctx_rdata)
	);

	adbq_ram #(.WIDTH(EDGE_W), .DEPTH(BAND_DEPTH)) u_band_ram (
		.clk   (clk),
		.we    (band_we),
		.waddr (band_waddr),
		.wdata (band_wdata),
		.raddr (band_raddr),
		.rdata (band_rdata)
	);

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign res_load = (state_q == ST_RESULT) && (!out_valid_q || res.ready);

	assign res.valid               = out_valid_q;
	assign res.payload.context_out = out_ctx_q;
	assign res.payload.event_res   = out_ev_q;

	// locate the context row
	assign in_range_d = (32'(req.payload.context_req) < NUM_CONTEXTS);
	assign base_d     = in_range_d
		? BAND_AW'(32'(req.payload.context_req) * NUM_BANDS) : '0;

	// split the context word
	assign prev = ctx_rdata[CTXW_W-1:PROF_W];
	assign prof = ctx_rdata[PROF_W-1:0];
	assign rise = prof[STEP_W-1:0];
	assign fall = prof[2*STEP_W-1:STEP_W];

	// incremental: move past the step in either direction
	assign up_sum   = {1'b0, prev} + (LAST_W+1)'(rise);
	assign inc_up   = (pos_q > prev) && (32'(up_sum) < FULL_SCALE)
		&& ({1'b0, pos_q} > up_sum);
	assign inc_down = !(pos_q > prev) && (prev > LAST_W'(fall))
		&& (pos_q < (prev - LAST_W'(fall)));

	// band walk: test the edge read for index k_q
	assign scaled   = SCALE_TAB[band_rdata];
	assign pos_c    = CMP_W'(pos_q);
	assign ge_lower = (pos_c >= CMP_W'(lower_q));
	assign in_top   = (32'(pos_q) <= FULL_SCALE);
	assign last_k   = (k_q == KW'(NUM_BANDS - 1));

	always_comb begin
		band_done = 1'b0;
		band_hit  = 1'b0;
		band_idx  = k_q;
		priority if (band_rdata == '0) begin
			band_done = 1'b1;
			band_hit  = ge_lower && in_top;
		end else if (ge_lower && (pos_c < CMP_W'(scaled))) begin
			band_done = 1'b1;
			band_hit  = 1'b1;
		end else if (last_k) begin
			band_done = 1'b1;
			band_hit  = (pos_c >= CMP_W'(scaled)) && in_top;
			band_idx  = KW'(NUM_BANDS);
		end else begin
			// keep walking to the next edge
			band_done = 1'b0;
		end
	end

	assign band_new = band_hit && (LAST_W'(band_idx) != prev);

	// edge word decode
	assign edge_num    = sel_q - SEL_W'(1);
	assign edge_sel_ok = (sel_q != SEL_MODE) && (32'(sel_q) <= NUM_BANDS);

	// prefetch the next edge during the walk
	always_comb begin
		band_raddr = base_q;
		if (state_q == ST_BAND && !last_k) begin
			band_raddr = base_q + BAND_AW'(k_q) + BAND_AW'(1);
		end
	end

	// RAM writes: clearing pass, profile writes, record updates
	always_comb begin
		ctx_we     = 1'b0;
		ctx_waddr  = ctx_addr_q;
		ctx_wdata  = ctx_rdata;
		band_we    = 1'b0;
		band_waddr = base_q + BAND_AW'(edge_num);
		band_wdata = data_q[EDGE_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ctx_we     = (32'(clr_q) < NUM_CONTEXTS);
				ctx_waddr  = clr_q[CTX_AW-1:0];
				ctx_wdata  = '0;
				band_we    = 1'b1;
				band_waddr = clr_q;
				band_wdata = '0;
			end
			ST_EVAL: begin
				if (op_q == OP_WRITE) begin
					if (in_range_q && sel_q == SEL_MODE) begin
						ctx_we    = 1'b1;
						ctx_wdata = {prev, data_q};
					end
					band_we = in_range_q && edge_sel_ok;
				end else if (in_range_q && prof[PROF_INC_BIT]) begin
					ctx_we    = inc_up || inc_down;
					ctx_wdata = {pos_q, prof};
				end
			end
			ST_BAND: begin
				ctx_we    = band_done && band_new;
				ctx_wdata = {LAST_W'(band_idx), prof};
			end
			ST_IDLE, ST_FETCH, ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	// sequence one item
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (32'(clr_q) == BAND_DEPTH - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (op_q == OP_WRITE) begin
					state_d = ST_IDLE;
				end else if (in_range_q && !prof[PROF_INC_BIT]) begin
					state_d = ST_BAND;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_BAND: begin
				if (band_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + BAND_AW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req.payload.op;
			ctx_q      <= req.payload.context_req;
			pos_q      <= req.payload.position;
			sel_q      <= req.payload.word_select;
			data_q     <= req.payload.word_data;
			in_range_q <= in_range_d;
			ctx_addr_q <= in_range_d ? CTX_AW'(req.payload.context_req) : '0;
			base_q     <= base_d;
		end
	end

	// advance the band walk and hold the pending event
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			k_q     <= '0;
			lower_q <= '0;
			if (!in_range_q) begin
				pend_ev_q <= EV_NONE;
			end else if (inc_up) begin
				pend_ev_q <= EV_UP;
			end else if (inc_down) begin
				pend_ev_q <= EV_DOWN;
			end else begin
				pend_ev_q <= EV_NONE;
			end
		end else if (state_q == ST_BAND) begin
			k_q     <= k_q + KW'(1);
			lower_q <= scaled;
			if (band_done) begin
				pend_ev_q <= band_new ? EV_W'(32'(band_idx) + 1) : EV_NONE;
			end
		end
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_ctx_q <= ctx_q;
			out_ev_q  <= pend_ev_q;
		end
	end

	// a result only comes from a sample
	a_result_from_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) |-> (op_q == OP_SAMPLE))
		else $error("result pending for a write request");

	// the band index stays inside the profile during the walk
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BAND) |-> (32'(k_q) < NUM_BANDS))
		else $error("band walk ran past the last edge");

	// outside the clearing pass an item writes at most one RAM
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |-> !(ctx_we && band_we))
		else $error("context and edge RAM written together");

	// res valid rises only after a result was loaded
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("result valid without a finished sample");

endmodule

// ----- sv/adbq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adbq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module adbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
